// ===== hw/rtl/sptw_pkg.sv =====
// Package: shared widths, reset values, register codes and types of the segmented page walker.
package sptw_pkg;

  // Fixed field widths
  localparam int unsigned VADDR_W    = 32;
  localparam int unsigned PFN_W      = 20;
  localparam int unsigned CNT_W      = 9;
  localparam int unsigned SEG_W      = 2;
  localparam int unsigned ENTRY_W    = 24;
  localparam int unsigned NUM_SEGS   = 4;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 20;

  // Parameter defaults
  localparam int unsigned SEG_PAGES_DEF  = 256;
  localparam int unsigned PAGE_SHIFT_DEF = 12;

  // Register reset values
  localparam logic [PFN_W-1:0] STACK_TOP_RST     = 20'h80000;
  localparam logic [PFN_W-1:0] DYNAMIC_START_RST = 20'd65600;
  localparam logic [PFN_W-1:0] STATIC_START_RST  = 20'd65536;
  localparam logic [PFN_W-1:0] TEXT_START_RST    = 20'd1024;

  // Segment codes
  localparam logic [SEG_W-1:0] SEG_STACK = 2'd0;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    RegStackLimit   = 3'd0,
    RegStackCount   = 3'd1,
    RegDynamicStart = 3'd2,
    RegDynamicCount = 3'd3,
    RegStaticStart  = 3'd4,
    RegStaticCount  = 3'd5,
    RegTextStart    = 3'd6,
    RegTextCount    = 3'd7
  } cfg_reg_e;

  // Request types
  localparam logic REQ_WALK = 1'b0;
  localparam logic REQ_MAP  = 1'b1;

  // Controller states, one-hot
  typedef enum logic [4:0] {
    StClear  = 5'b00001,
    StIdle   = 5'b00010,
    StLocate = 5'b00100,
    StRead   = 5'b01000,
    StResp   = 5'b10000
  } state_e;

  typedef struct packed {
    logic               req_type;
    logic [VADDR_W-1:0] vaddr;
    logic [PFN_W-1:0]   vpn;
    logic [PFN_W-1:0]   entry_pfn;
    logic               entry_global;
    logic               entry_present;
    logic               entry_user;
    logic               entry_writable;
  } req_t;

  typedef struct packed {
    logic             found;
    logic [SEG_W-1:0] segment;
    logic [PFN_W-1:0] pfn;
    logic             global_flag;
    logic             present_flag;
    logic             user_flag;
    logic             writable_flag;
    logic [PFN_W-1:0] replaced_pfn;
  } rsp_t;

  // Controller to datapath commands
  typedef struct packed {
    logic clr_wr;
    logic capture;
    logic locate;
    logic read;
    logic load_out;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic clr_last;
  } sts_t;

endpackage

// ===== hw/rtl/sptw_if.sv =====
// Interfaces: request, response and configuration channels of the page walker.
interface sptw_req_if;
  logic                          valid;
  logic                          ready;
  logic                          req_type;
  logic [sptw_pkg::VADDR_W-1:0]  vaddr;
  logic [sptw_pkg::PFN_W-1:0]    vpn;
  logic [sptw_pkg::PFN_W-1:0]    entry_pfn;
  logic                          entry_global;
  logic                          entry_present;
  logic                          entry_user;
  logic                          entry_writable;

  modport source (
    output valid, req_type, vaddr, vpn, entry_pfn, entry_global, entry_present,
           entry_user, entry_writable,
    input  ready
  );
  modport sink (
    input  valid, req_type, vaddr, vpn, entry_pfn, entry_global, entry_present,
           entry_user, entry_writable,
    output ready
  );
endinterface

interface sptw_rsp_if;
  logic                        valid;
  logic                        ready;
  logic                        found;
  logic [sptw_pkg::SEG_W-1:0]  segment;
  logic [sptw_pkg::PFN_W-1:0]  pfn;
  logic                        global_flag;
  logic                        present_flag;
  logic                        user_flag;
  logic                        writable_flag;
  logic [sptw_pkg::PFN_W-1:0]  replaced_pfn;

  modport source (
    output valid, found, segment, pfn, global_flag, present_flag, user_flag,
           writable_flag, replaced_pfn,
    input  ready
  );
  modport sink (
    input  valid, found, segment, pfn, global_flag, present_flag, user_flag,
           writable_flag, replaced_pfn,
    output ready
  );
endinterface

interface sptw_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [sptw_pkg::CFG_IDX_W-1:0]   reg_idx;
  logic [sptw_pkg::CFG_DATA_W-1:0]  wdata;

  modport source (output valid, reg_idx, wdata, input ready);
  modport sink (input valid, reg_idx, wdata, output ready);
endinterface

// ===== hw/rtl/sptw_ctrl.sv =====
// Controller: state machine that sequences clearing, capture, locate, read and response.
module sptw_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             req_valid_i,
  output logic             req_ready_o,
  output logic             rsp_valid_o,
  input  logic             rsp_ready_i,
  input  sptw_pkg::sts_t   sts_i,
  output sptw_pkg::cmd_t   cmd_o
);

  sptw_pkg::state_e state_q, state_d;
  logic             out_valid_q, out_valid_d;

  // Next state and commands
  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    cmd_o       = '0;
    req_ready_o = 1'b0;
    // drop the held result once it is transferred
    if (out_valid_q && rsp_ready_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      sptw_pkg::StClear: begin
        cmd_o.clr_wr = 1'b1;
        if (sts_i.clr_last) begin
          state_d = sptw_pkg::StIdle;
        end
      end
      sptw_pkg::StIdle: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = sptw_pkg::StLocate;
        end
      end
      sptw_pkg::StLocate: begin
        cmd_o.locate = 1'b1;
        state_d      = sptw_pkg::StRead;
      end
      sptw_pkg::StRead: begin
        cmd_o.read = 1'b1;
        state_d    = sptw_pkg::StResp;
      end
      sptw_pkg::StResp: begin
        // hold until the output register is free
        if (!out_valid_q || rsp_ready_i) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = sptw_pkg::StIdle;
        end
      end
      default: begin
        state_d = sptw_pkg::StIdle;
      end
    endcase
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sptw_pkg::StClear;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign rsp_valid_o = out_valid_q;

endmodule

// ===== hw/rtl/sptw_dpath.sv =====
// Datapath: configuration registers, segment match, entry store and result register.
module sptw_dpath #(
  parameter int unsigned SEG_PAGES  = sptw_pkg::SEG_PAGES_DEF,
  parameter int unsigned PAGE_SHIFT = sptw_pkg::PAGE_SHIFT_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  sptw_pkg::cmd_t                    cmd_i,
  output sptw_pkg::sts_t                    sts_o,
  input  sptw_pkg::req_t                    req_i,
  output sptw_pkg::rsp_t                    rsp_o,
  input  logic                              cfg_we_i,
  input  logic [sptw_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [sptw_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  localparam int unsigned DEPTH = sptw_pkg::NUM_SEGS * SEG_PAGES;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned PW    = sptw_pkg::VADDR_W - PAGE_SHIFT;
  localparam int unsigned PGW   = (PW > sptw_pkg::PFN_W) ? PW : sptw_pkg::PFN_W;
  localparam int unsigned W     = PGW + 1;
  localparam int unsigned SPW   = $clog2(SEG_PAGES + 1);
  localparam int unsigned CW    = (SPW > sptw_pkg::CNT_W) ? SPW : sptw_pkg::CNT_W;

  // Configuration: base page (stack limit for segment zero) and page count
  logic [sptw_pkg::PFN_W-1:0] base_q [sptw_pkg::NUM_SEGS];
  logic [sptw_pkg::CNT_W-1:0] cnt_q  [sptw_pkg::NUM_SEGS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q[0] <= sptw_pkg::STACK_TOP_RST;
      base_q[1] <= sptw_pkg::DYNAMIC_START_RST;
      base_q[2] <= sptw_pkg::STATIC_START_RST;
      base_q[3] <= sptw_pkg::TEXT_START_RST;
      cnt_q[0]  <= '0;
      cnt_q[1]  <= '0;
      cnt_q[2]  <= '0;
      cnt_q[3]  <= '0;
    end else if (cfg_we_i) begin
      unique case (sptw_pkg::cfg_reg_e'(cfg_idx_i))
        sptw_pkg::RegStackLimit:   base_q[0] <= cfg_data_i;
        sptw_pkg::RegStackCount:   cnt_q[0]  <= cfg_data_i[sptw_pkg::CNT_W-1:0];
        sptw_pkg::RegDynamicStart: base_q[1] <= cfg_data_i;
        sptw_pkg::RegDynamicCount: cnt_q[1]  <= cfg_data_i[sptw_pkg::CNT_W-1:0];
        sptw_pkg::RegStaticStart:  base_q[2] <= cfg_data_i;
        sptw_pkg::RegStaticCount:  cnt_q[2]  <= cfg_data_i[sptw_pkg::CNT_W-1:0];
        sptw_pkg::RegTextStart:    base_q[3] <= cfg_data_i;
        sptw_pkg::RegTextCount:    cnt_q[3]  <= cfg_data_i[sptw_pkg::CNT_W-1:0];
      endcase
    end
  end

  // Capture the request: page number, kind and new entry
  logic [PGW-1:0]                 page_q;
  logic                           map_q;
  logic [sptw_pkg::ENTRY_W-1:0]   entry_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      map_q   <= (req_i.req_type == sptw_pkg::REQ_MAP);
      page_q  <= (req_i.req_type == sptw_pkg::REQ_MAP)
                 ? PGW'(req_i.vpn)
                 : PGW'(req_i.vaddr[sptw_pkg::VADDR_W-1:PAGE_SHIFT]);
      entry_q <= {req_i.entry_writable, req_i.entry_user, req_i.entry_present,
                  req_i.entry_global, req_i.entry_pfn};
    end
  end

  // Match the page against all segments, lowest segment wins
  logic [CW-1:0]             ccnt [sptw_pkg::NUM_SEGS];
  logic [W-1:0]              pg_ext;
  logic [W-1:0]              lim_ext;
  logic [W-1:0]              stk_diff;
  logic [W-1:0]              stk_dm1;
  logic [W-1:0]              offs [sptw_pkg::NUM_SEGS];
  logic                      hit_d;
  logic [sptw_pkg::SEG_W-1:0] seg_d;
  logic [AW-1:0]             slot_d;

  always_comb begin
    for (int s = 0; s < int'(sptw_pkg::NUM_SEGS); s++) begin
      ccnt[s] = (CW'(cnt_q[s]) > CW'(SEG_PAGES)) ? CW'(SEG_PAGES) : CW'(cnt_q[s]);
    end
    pg_ext   = W'(page_q);
    lim_ext  = W'(base_q[0]);
    stk_diff = lim_ext - pg_ext;
    stk_dm1  = stk_diff - W'(1);
    hit_d    = 1'b0;
    seg_d    = '0;
    slot_d   = '0;
    offs[0]  = '0;
    for (int s = int'(sptw_pkg::NUM_SEGS) - 1; s >= 1; s--) begin
      offs[s] = pg_ext - W'(base_q[s]);
      if ((pg_ext >= W'(base_q[s])) && (offs[s] < W'(ccnt[s]))) begin
        hit_d  = 1'b1;
        seg_d  = sptw_pkg::SEG_W'(s);
        slot_d = AW'(s * int'(SEG_PAGES)) + offs[s][AW-1:0];
      end
    end
    if ((pg_ext < lim_ext) && (stk_diff <= W'(ccnt[0]))) begin
      hit_d  = 1'b1;
      seg_d  = sptw_pkg::SEG_STACK;
      slot_d = stk_dm1[AW-1:0];
    end
  end

  logic                       hit_q;
  logic [sptw_pkg::SEG_W-1:0] seg_q;
  logic [AW-1:0]              slot_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.locate) begin
      hit_q  <= hit_d;
      seg_q  <= seg_d;
      slot_q <= slot_d;
    end
  end

  // Clearing pass address
  logic [AW-1:0] clr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.clr_wr) begin
      clr_q <= clr_q + AW'(1);
    end
  end

  assign sts_o.clr_last = (clr_q == AW'(DEPTH - 1));

  // Entry store: one write port, one registered read port
  logic [sptw_pkg::ENTRY_W-1:0] mem_q [DEPTH];
  logic [sptw_pkg::ENTRY_W-1:0] rd_q;
  logic                         mem_we;
  logic [AW-1:0]                mem_waddr;
  logic [sptw_pkg::ENTRY_W-1:0] mem_wdata;

  assign mem_we    = cmd_i.clr_wr || (cmd_i.load_out && map_q && hit_q);
  assign mem_waddr = cmd_i.clr_wr ? clr_q : slot_q;
  assign mem_wdata = cmd_i.clr_wr ? '0 : entry_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (cmd_i.read) begin
      rd_q <= mem_q[slot_q];
    end
  end

  // Result register
  sptw_pkg::rsp_t rsp_q, rsp_d;

  always_comb begin
    rsp_d = '0;
    if (hit_q) begin
      rsp_d.found   = 1'b1;
      rsp_d.segment = seg_q;
      if (map_q) begin
        rsp_d.replaced_pfn = rd_q[sptw_pkg::PFN_W-1:0];
      end else begin
        rsp_d.pfn           = rd_q[sptw_pkg::PFN_W-1:0];
        rsp_d.global_flag   = rd_q[20];
        rsp_d.present_flag  = rd_q[21];
        rsp_d.user_flag     = rd_q[22];
        rsp_d.writable_flag = rd_q[23];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      rsp_q <= rsp_d;
    end
  end

  assign rsp_o = rsp_q;

endmodule

// ===== hw/rtl/segmented_page_table_walk.sv =====
// A request transfer is followed by the locate, read and respond steps; respond waits while
// the output register holds an untaken result. Only one walk or map is in flight at a time.
// A result waits in the output register while the next request is taken.
// Reset: configuration returns to defaults, then a clearing pass writes all 4*SEG_PAGES
// entries to zero, one per cycle; requests wait, config is taken.
module segmented_page_table_walk #(
  parameter int unsigned SEG_PAGES  = sptw_pkg::SEG_PAGES_DEF,
  parameter int unsigned PAGE_SHIFT = sptw_pkg::PAGE_SHIFT_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  sptw_req_if.sink    req,
  sptw_rsp_if.source  rsp,
  sptw_cfg_if.sink    cfg
);

  sptw_pkg::cmd_t cmd;
  sptw_pkg::sts_t sts;
  sptw_pkg::req_t req_pl;
  sptw_pkg::rsp_t rsp_pl;

  // Pack the request payload
  assign req_pl.req_type       = req.req_type;
  assign req_pl.vaddr          = req.vaddr;
  assign req_pl.vpn            = req.vpn;
  assign req_pl.entry_pfn      = req.entry_pfn;
  assign req_pl.entry_global   = req.entry_global;
  assign req_pl.entry_present  = req.entry_present;
  assign req_pl.entry_user     = req.entry_user;
  assign req_pl.entry_writable = req.entry_writable;

  // Configuration writes are always taken
  assign cfg.ready = 1'b1;

  sptw_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req.valid),
    .req_ready_o (req.ready),
    .rsp_valid_o (rsp.valid),
    .rsp_ready_i (rsp.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  sptw_dpath #(
    .SEG_PAGES  (SEG_PAGES),
    .PAGE_SHIFT (PAGE_SHIFT)
  ) u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .req_i      (req_pl),
    .rsp_o      (rsp_pl),
    .cfg_we_i   (cfg.valid),
    .cfg_idx_i  (cfg.reg_idx),
    .cfg_data_i (cfg.wdata)
  );

  // Unpack the result payload
  assign rsp.found         = rsp_pl.found;
  assign rsp.segment       = rsp_pl.segment;
  assign rsp.pfn           = rsp_pl.pfn;
  assign rsp.global_flag   = rsp_pl.global_flag;
  assign rsp.present_flag  = rsp_pl.present_flag;
  assign rsp.user_flag     = rsp_pl.user_flag;
  assign rsp.writable_flag = rsp_pl.writable_flag;
  assign rsp.replaced_pfn  = rsp_pl.replaced_pfn;

  // A request transfer is followed by the segment match
  a_capture_locate: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.capture |=> cmd.locate)
    else $error("locate did not follow request transfer");

  // A new result never overwrites one that is still waiting
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_out |-> (!rsp.valid || rsp.ready))
    else $error("result register overwritten while pending");

  // No request is taken during the clearing pass
  a_clear_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.clr_wr |-> !req.ready)
    else $error("request ready during clearing pass");

  // A transferred result is not shown again
  a_no_repeat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp.valid && rsp.ready && !cmd.load_out) |=> !rsp.valid)
    else $error("result repeated after transfer");

endmodule

// ===== bench/tb_segmented_page_table_walk.sv =====
// Testbench for the segmented page table walker: directed and random walks and maps, self-checked.
`timescale 1ns / 1ps

module tb_segmented_page_table_walk;

  localparam int unsigned SEG_PAGES   = sptw_pkg::SEG_PAGES_DEF;
  localparam int unsigned PAGE_SHIFT  = sptw_pkg::PAGE_SHIFT_DEF;
  localparam int unsigned VADDR_W     = sptw_pkg::VADDR_W;
  localparam int unsigned PFN_W       = sptw_pkg::PFN_W;
  localparam int unsigned CNT_W       = sptw_pkg::CNT_W;
  localparam int unsigned SEG_W       = sptw_pkg::SEG_W;
  localparam int unsigned ENTRY_W     = sptw_pkg::ENTRY_W;
  localparam int unsigned NUM_SEGS    = sptw_pkg::NUM_SEGS;
  localparam int unsigned CFG_DATA_W  = sptw_pkg::CFG_DATA_W;
  localparam int unsigned RSP_LATENCY = 3;
  localparam int unsigned IDLE_PCT    = 37;
  localparam int unsigned PHASE_ITEMS = 110;

  typedef sptw_pkg::req_t     req_t;
  typedef sptw_pkg::rsp_t     rsp_t;
  typedef sptw_pkg::cfg_reg_e cfg_reg_e;

  // Segment codes beyond the stack
  localparam logic [SEG_W-1:0] SEG_DYNAMIC = 2'd1;
  localparam logic [SEG_W-1:0] SEG_STATIC  = 2'd2;
  localparam logic [SEG_W-1:0] SEG_TEXT    = 2'd3;

  localparam rsp_t NO_HIT = '0;

  typedef struct {
    bit                    is_cfg;
    cfg_reg_e              reg_idx;
    logic [CFG_DATA_W-1:0] wdata;
    req_t                  item;
    bit                    typed;
    rsp_t                  want;
  } dir_row_t;

  logic clk_i;
  logic rst_ni;

  sptw_req_if req_ch ();
  sptw_rsp_if rsp_ch ();
  sptw_cfg_if cfg_ch ();

  segmented_page_table_walk u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req    (req_ch),
    .rsp    (rsp_ch),
    .cfg    (cfg_ch)
  );

  // Shadow of the configuration and of the entry store
  logic [PFN_W-1:0]   stack_top;
  logic [PFN_W-1:0]   seg_base   [1:3];
  logic [CNT_W-1:0]   seg_count  [0:3];
  logic [ENTRY_W-1:0] page_entries [NUM_SEGS*SEG_PAGES];

  rsp_t     pending_rsp [$];
  dir_row_t directed_rows [$];
  int       fail_count;
  bit       calm;
  bit       hold_now;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #4_800_000;
    $display("tb_segmented_page_table_walk: done, errors");
    $finish;
  end

  // Pages in use in a segment, capped at its capacity
  function automatic int unsigned seg_span(input int s);
    return (seg_count[s] > SEG_PAGES) ? SEG_PAGES : seg_count[s];
  endfunction

  function automatic bit locate_page(input int unsigned page, output int seg, output int slot);
    int unsigned lim;
    lim  = stack_top;
    seg  = 0;
    slot = 0;
    if (page < lim && lim - page <= seg_span(0)) begin
      slot = lim - 1 - page;
      return 1'b1;
    end
    for (int s = 1; s < NUM_SEGS; s++) begin
      if (page >= seg_base[s] && page - seg_base[s] < seg_span(s)) begin
        seg  = s;
        slot = s * SEG_PAGES + (page - seg_base[s]);
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  // Work out the result of one request and apply a map to the shadow store
  function automatic rsp_t translate(input req_t r);
    rsp_t        res;
    int          seg;
    int          slot;
    int unsigned page;
    res = '0;
    if (r.req_type == sptw_pkg::REQ_WALK) begin
      page = r.vaddr >> PAGE_SHIFT;
      if (locate_page(page, seg, slot)) begin
        res.found   = 1'b1;
        res.segment = SEG_W'(seg);
        {res.writable_flag, res.user_flag, res.present_flag, res.global_flag, res.pfn} =
          page_entries[slot];
      end
    end else if (locate_page(r.vpn, seg, slot)) begin
      res.found        = 1'b1;
      res.segment      = SEG_W'(seg);
      res.replaced_pfn = page_entries[slot][PFN_W-1:0];
      page_entries[slot] = {r.entry_writable, r.entry_user, r.entry_present, r.entry_global,
                            r.entry_pfn};
    end
    return res;
  endfunction

  function automatic rsp_t hit(input logic [SEG_W-1:0] seg, input logic [PFN_W-1:0] pfn,
                               input logic [3:0] fl, input logic [PFN_W-1:0] old_pfn);
    return '{1'b1, seg, pfn, fl[3], fl[2], fl[1], fl[0], old_pfn};
  endfunction

  function automatic dir_row_t blank_row();
    dir_row_t row;
    row.is_cfg  = 1'b0;
    row.reg_idx = sptw_pkg::RegStackLimit;
    row.wdata   = '0;
    row.item    = '0;
    row.typed   = 1'b0;
    row.want    = '0;
    return row;
  endfunction

  function automatic dir_row_t step_cfg(input cfg_reg_e idx, input int unsigned d);
    dir_row_t row;
    row = blank_row();
    row.is_cfg  = 1'b1;
    row.reg_idx = idx;
    row.wdata   = CFG_DATA_W'(d);
    return row;
  endfunction

  // fl is {global, present, user, writable}
  function automatic dir_row_t step_req(input logic t, input logic [VADDR_W-1:0] va,
                                        input logic [PFN_W-1:0] vpn,
                                        input logic [PFN_W-1:0] pfn, input logic [3:0] fl,
                                        input bit typed, input rsp_t want);
    dir_row_t row;
    row = blank_row();
    row.item  = '{t, va, vpn, pfn, fl[3], fl[2], fl[1], fl[0]};
    row.typed = typed;
    row.want  = want;
    return row;
  endfunction

  // Append one row to the directed table
  function automatic void add_row(input dir_row_t row);
    directed_rows.insert(directed_rows.size(), row);
  endfunction

  function automatic req_t pick_request();
    req_t        r;
    int          s;
    int          off;
    int          page;
    int unsigned cnt;
    r.req_type       = ($urandom_range(0, 99) < 45) ? sptw_pkg::REQ_MAP : sptw_pkg::REQ_WALK;
    r.vaddr          = $urandom;
    r.vpn            = PFN_W'($urandom);
    r.entry_pfn      = PFN_W'($urandom);
    r.entry_global   = 1'($urandom_range(0, 1));
    r.entry_present  = 1'($urandom_range(0, 1));
    r.entry_user     = 1'($urandom_range(0, 1));
    r.entry_writable = 1'($urandom_range(0, 1));
    // Most requests aim at a segment or just past one of its edges
    if ($urandom_range(0, 99) < 78) begin
      s   = $urandom_range(0, NUM_SEGS - 1);
      cnt = seg_span(s);
      off = int'($urandom_range(0, cnt + 3)) - 2;
      if (s == 0) begin
        page = int'(stack_top) - 1 - off;
      end else begin
        page = int'(seg_base[s]) + off;
      end
      if (page >= 0 && page < (1 << PFN_W)) begin
        r.vpn   = PFN_W'(page);
        r.vaddr = {PFN_W'(page), r.vaddr[PAGE_SHIFT-1:0]};
      end
    end
    return r;
  endfunction

  function automatic void cmp_field(input string name, input logic [PFN_W-1:0] want_v,
                                    input logic [PFN_W-1:0] got_v);
    if (got_v !== want_v) begin
      $error("%s: expected %0h, got %0h", name, want_v, got_v);
      fail_count++;
    end
  endfunction

  // Offer one request, idling at random first; valid stays high after the transfer
  task automatic push_req(input req_t r, input bit typed, input rsp_t want);
    rsp_t predicted;
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      req_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_ch.valid          <= 1'b1;
    req_ch.req_type       <= r.req_type;
    req_ch.vaddr          <= r.vaddr;
    req_ch.vpn            <= r.vpn;
    req_ch.entry_pfn      <= r.entry_pfn;
    req_ch.entry_global   <= r.entry_global;
    req_ch.entry_present  <= r.entry_present;
    req_ch.entry_user     <= r.entry_user;
    req_ch.entry_writable <= r.entry_writable;
    do @(posedge clk_i); while (!req_ch.ready);
    predicted = translate(r);
    pending_rsp.insert(pending_rsp.size(), typed ? want : predicted);
  endtask

  // Stop offering and wait until every result is back and the block is quiet
  task automatic drain_results();
    req_ch.valid <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk_i);
    repeat (RSP_LATENCY + 1) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input int unsigned d);
    logic [CFG_DATA_W-1:0] data;
    data = CFG_DATA_W'(d);
    cfg_ch.valid   <= 1'b1;
    cfg_ch.reg_idx <= idx;
    cfg_ch.wdata   <= data;
    do @(posedge clk_i); while (!cfg_ch.ready);
    case (idx)
      sptw_pkg::RegStackLimit:   stack_top    = data;
      sptw_pkg::RegStackCount:   seg_count[0] = data[CNT_W-1:0];
      sptw_pkg::RegDynamicStart: seg_base[1]  = data;
      sptw_pkg::RegDynamicCount: seg_count[1] = data[CNT_W-1:0];
      sptw_pkg::RegStaticStart:  seg_base[2]  = data;
      sptw_pkg::RegStaticCount:  seg_count[2] = data[CNT_W-1:0];
      sptw_pkg::RegTextStart:    seg_base[3]  = data;
      sptw_pkg::RegTextCount:    seg_count[3] = data[CNT_W-1:0];
      default: ;
    endcase
  endtask

  task automatic close_cfg();
    cfg_ch.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  // Segment layout for each random phase
  task automatic set_phase_config(input int ph);
    int unsigned base;
    base = $urandom_range(0, 20'hFFC00);
    case (ph)
      0: begin
        write_reg(sptw_pkg::RegStackLimit, $urandom_range(SEG_PAGES, 20'hFFFFF));
        write_reg(sptw_pkg::RegDynamicStart, $urandom_range(0, 20'hFFFFF));
        write_reg(sptw_pkg::RegStaticStart, $urandom_range(0, 20'hFFFFF));
        write_reg(sptw_pkg::RegTextStart, $urandom_range(0, 20'hFFFFF));
        write_reg(sptw_pkg::RegStackCount, SEG_PAGES);
        write_reg(sptw_pkg::RegDynamicCount, SEG_PAGES);
        write_reg(sptw_pkg::RegStaticCount, SEG_PAGES);
        write_reg(sptw_pkg::RegTextCount, SEG_PAGES);
      end
      1: begin
        // Overlapping segments exercise the lookup priority
        write_reg(sptw_pkg::RegStackLimit, base + $urandom_range(0, 600));
        write_reg(sptw_pkg::RegDynamicStart, base);
        write_reg(sptw_pkg::RegStaticStart, base + $urandom_range(0, 300));
        write_reg(sptw_pkg::RegTextStart, base + $urandom_range(0, 300));
        write_reg(sptw_pkg::RegStackCount, $urandom_range(0, SEG_PAGES));
        write_reg(sptw_pkg::RegDynamicCount, $urandom_range(0, SEG_PAGES));
        write_reg(sptw_pkg::RegStaticCount, $urandom_range(0, SEG_PAGES));
        write_reg(sptw_pkg::RegTextCount, $urandom_range(0, SEG_PAGES));
      end
      2: begin
        write_reg(sptw_pkg::RegStackLimit, $urandom_range(0, 20'hFFFFF));
        write_reg(sptw_pkg::RegDynamicStart, base);
        write_reg(sptw_pkg::RegStaticStart, base + 4);
        write_reg(sptw_pkg::RegTextStart, $urandom_range(0, 20'hFFFFF));
        write_reg(sptw_pkg::RegStackCount, $urandom_range(0, 3));
        write_reg(sptw_pkg::RegDynamicCount, $urandom_range(0, 3));
        write_reg(sptw_pkg::RegStaticCount, $urandom_range(0, 3));
        write_reg(sptw_pkg::RegTextCount, $urandom_range(0, 3));
      end
      3: begin
        // Top of the page space and counts past capacity
        write_reg(sptw_pkg::RegStackLimit, 20'hFFFFF);
        write_reg(sptw_pkg::RegDynamicStart, 20'hFFFFF);
        write_reg(sptw_pkg::RegStaticStart, 20'hFFF80);
        write_reg(sptw_pkg::RegTextStart, 0);
        write_reg(sptw_pkg::RegStackCount, 511);
        write_reg(sptw_pkg::RegDynamicCount, SEG_PAGES);
        write_reg(sptw_pkg::RegStaticCount, 300);
        write_reg(sptw_pkg::RegTextCount, SEG_PAGES);
      end
      default: begin
        write_reg(sptw_pkg::RegStackLimit, $urandom_range(0, 20'hFFFFF));
        write_reg(sptw_pkg::RegDynamicStart, $urandom_range(0, 20'hFFFFF));
        write_reg(sptw_pkg::RegStaticStart, $urandom_range(0, 20'hFFFFF));
        write_reg(sptw_pkg::RegTextStart, $urandom_range(0, 20'hFFFFF));
        write_reg(sptw_pkg::RegStackCount, $urandom_range(0, 511));
        write_reg(sptw_pkg::RegDynamicCount, $urandom_range(0, 511));
        write_reg(sptw_pkg::RegStaticCount, $urandom_range(0, 511));
        write_reg(sptw_pkg::RegTextCount, $urandom_range(0, 511));
      end
    endcase
  endtask

  // Response side: random back-pressure plus one long hold-off
  initial begin
    rsp_ch.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_now) begin
        hold_now = 1'b0;
        rsp_ch.ready <= 1'b0;
        repeat (200) @(posedge clk_i);
      end else begin
        rsp_ch.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  // Compare each result transfer with the oldest expectation
  always @(posedge clk_i) begin
    rsp_t want;
    if (rst_ni && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_rsp.size() == 0) begin
        $error("result transfer with no request outstanding");
        fail_count++;
      end else begin
        want = pending_rsp.pop_front();
        cmp_field("found", PFN_W'(want.found), PFN_W'(rsp_ch.found));
        cmp_field("segment", PFN_W'(want.segment), PFN_W'(rsp_ch.segment));
        cmp_field("pfn", want.pfn, rsp_ch.pfn);
        cmp_field("global_flag", PFN_W'(want.global_flag), PFN_W'(rsp_ch.global_flag));
        cmp_field("present_flag", PFN_W'(want.present_flag), PFN_W'(rsp_ch.present_flag));
        cmp_field("user_flag", PFN_W'(want.user_flag), PFN_W'(rsp_ch.user_flag));
        cmp_field("writable_flag", PFN_W'(want.writable_flag),
                  PFN_W'(rsp_ch.writable_flag));
        cmp_field("replaced_pfn", want.replaced_pfn, rsp_ch.replaced_pfn);
      end
    end
  end

  // Stimulus
  initial begin
    bit cfg_open;
    fail_count = 0;
    calm       = 1'b0;
    hold_now   = 1'b0;
    cfg_open   = 1'b0;

    stack_top    = sptw_pkg::STACK_TOP_RST;
    seg_base[1]  = sptw_pkg::DYNAMIC_START_RST;
    seg_base[2]  = sptw_pkg::STATIC_START_RST;
    seg_base[3]  = sptw_pkg::TEXT_START_RST;
    seg_count    = '{default: '0};
    page_entries = '{default: '0};

    rst_ni                = 1'b0;
    req_ch.valid          = 1'b0;
    req_ch.req_type       = sptw_pkg::REQ_WALK;
    req_ch.vaddr          = '0;
    req_ch.vpn            = '0;
    req_ch.entry_pfn      = '0;
    req_ch.entry_global   = 1'b0;
    req_ch.entry_present  = 1'b0;
    req_ch.entry_user     = 1'b0;
    req_ch.entry_writable = 1'b0;
    cfg_ch.valid          = 1'b0;
    cfg_ch.reg_idx        = sptw_pkg::RegStackLimit;
    cfg_ch.wdata          = '0;

    // All counts zero after reset: nothing hits
    add_row(step_req(sptw_pkg::REQ_WALK, 32'h0, 0, 0, 4'h0, 1, NO_HIT));
    add_row(step_req(sptw_pkg::REQ_MAP, 32'h0, 20'h7FFFF, 20'h55555, 4'hF, 1, NO_HIT));
    // Fill the segments; text count past capacity
    add_row(step_cfg(sptw_pkg::RegStackCount, SEG_PAGES));
    add_row(step_cfg(sptw_pkg::RegDynamicCount, 16));
    add_row(step_cfg(sptw_pkg::RegStaticCount, SEG_PAGES));
    add_row(step_cfg(sptw_pkg::RegTextCount, 511));
    // Stack top and bottom slots
    add_row(step_req(sptw_pkg::REQ_MAP, 32'h0, 20'h7FFFF, 20'hFFFFF, 4'hF, 1,
                     hit(sptw_pkg::SEG_STACK, 0, 4'h0, 0)));
    add_row(step_req(sptw_pkg::REQ_WALK, 32'h7FFFFFFF, 0, 0, 4'h0, 1,
                     hit(sptw_pkg::SEG_STACK, 20'hFFFFF, 4'hF, 0)));
    add_row(step_req(sptw_pkg::REQ_MAP, 32'h0, 20'h7FF00, 20'h12345, 4'b0101, 1,
                     hit(sptw_pkg::SEG_STACK, 0, 4'h0, 0)));
    add_row(step_req(sptw_pkg::REQ_WALK, 32'h7FF00000, 0, 0, 4'h0, 1,
                     hit(sptw_pkg::SEG_STACK, 20'h12345, 4'b0101, 0)));
    // Just below the stack and at the limit itself
    add_row(step_req(sptw_pkg::REQ_WALK, 32'h7FEFF000, 0, 0, 4'h0, 1, NO_HIT));
    add_row(step_req(sptw_pkg::REQ_WALK, 32'h80000000, 0, 0, 4'h0, 1, NO_HIT));
    // Dynamic overlaps static and wins; remap reports the old frame
    add_row(step_req(sptw_pkg::REQ_MAP, 32'h0, 20'h10040, 20'hABCDE, 4'b1010, 1,
                     hit(SEG_DYNAMIC, 0, 4'h0, 0)));
    add_row(step_req(sptw_pkg::REQ_MAP, 32'h0, 20'h10040, 20'h00001, 4'b0011, 1,
                     hit(SEG_DYNAMIC, 0, 4'h0, 20'hABCDE)));
    add_row(step_req(sptw_pkg::REQ_WALK, 32'h10040FFF, 0, 0, 4'h0, 0, NO_HIT));
    add_row(step_req(sptw_pkg::REQ_MAP, 32'h0, 20'h1003F, 20'h2468A, 4'b1100, 0, NO_HIT));
    add_row(step_req(sptw_pkg::REQ_MAP, 32'h0, 20'h10050, 20'h13579, 4'b0110, 0, NO_HIT));
    add_row(step_req(sptw_pkg::REQ_MAP, 32'h0, 20'h100FF, 20'hFFFFE, 4'b1001, 0, NO_HIT));
    add_row(step_req(sptw_pkg::REQ_WALK, 32'h10100000, 0, 0, 4'h0, 1, NO_HIT));
    // Text count capped at capacity
    add_row(step_req(sptw_pkg::REQ_MAP, 32'h0, 20'h004FF, 20'h00ABC, 4'b0111, 1,
                     hit(SEG_TEXT, 0, 4'h0, 0)));
    add_row(step_req(sptw_pkg::REQ_WALK, 32'h00500000, 0, 0, 4'h0, 1, NO_HIT));
    add_row(step_req(sptw_pkg::REQ_WALK, 32'h003FFFFF, 0, 0, 4'h0, 1, NO_HIT));
    add_row(step_req(sptw_pkg::REQ_WALK, 32'hFFFFFFFF, 0, 0, 4'h0, 1, NO_HIT));
    // Segments at both ends of the page space, no wrap past the top
    add_row(step_cfg(sptw_pkg::RegStackLimit, 0));
    add_row(step_cfg(sptw_pkg::RegDynamicStart, 20'hFFFFF));
    add_row(step_cfg(sptw_pkg::RegDynamicCount, SEG_PAGES));
    add_row(step_cfg(sptw_pkg::RegStaticStart, 0));
    add_row(step_cfg(sptw_pkg::RegStaticCount, 1));
    add_row(step_cfg(sptw_pkg::RegTextStart, 20'hFFF00));
    add_row(step_cfg(sptw_pkg::RegTextCount, 0));
    add_row(step_req(sptw_pkg::REQ_WALK, 32'hFFFFFFFF, 0, 0, 4'h0, 0, NO_HIT));
    add_row(step_req(sptw_pkg::REQ_MAP, 32'h0, 20'h0, 20'h0F0F0, 4'hF, 0, NO_HIT));
    add_row(step_req(sptw_pkg::REQ_WALK, 32'h00000FFF, 0, 0, 4'h0, 0, NO_HIT));
    add_row(step_req(sptw_pkg::REQ_MAP, 32'h0, 20'h1, 20'h11111, 4'hF, 1, NO_HIT));
    // Stack of one page right under the top
    add_row(step_cfg(sptw_pkg::RegStackLimit, 20'hFFFFF));
    add_row(step_cfg(sptw_pkg::RegStackCount, 1));
    add_row(step_req(sptw_pkg::REQ_WALK, 32'hFFFFE000, 0, 0, 4'h0, 0, NO_HIT));
    add_row(step_req(sptw_pkg::REQ_WALK, 32'hFFFFF000, 0, 0, 4'h0, 0, NO_HIT));

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Walk the directed rows; register writes only once the block is idle
    foreach (directed_rows[i]) begin
      if (directed_rows[i].is_cfg) begin
        if (!cfg_open) begin
          drain_results();
          cfg_open = 1'b1;
        end
        write_reg(directed_rows[i].reg_idx, 32'(directed_rows[i].wdata));
      end else begin
        if (cfg_open) begin
          close_cfg();
          cfg_open = 1'b0;
        end
        push_req(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);
      end
    end

    // Random phases, each with its own segment layout
    for (int ph = 0; ph < 5; ph++) begin
      drain_results();
      set_phase_config(ph);
      close_cfg();
      calm = (ph == 2);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (ph == 1 && n == 40) hold_now = 1'b1;
        if (ph == 3 && n == 50) drain_results();
        push_req(pick_request(), 1'b0, NO_HIT);
      end
    end
    calm = 1'b0;
    drain_results();
    repeat (4) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("tb_segmented_page_table_walk: done, clean");
    end else begin
      $display("tb_segmented_page_table_walk: done, errors");
    end
    $finish;
  end

endmodule
